[design/bsram_pkg.sv]
// Shared constants and types for the banked SRAM emulator.
// No dependencies; the top level uses it through scoped names.
package bsram_pkg;

	// Default geometry of the emulated chips
	localparam int DEF_BANK_DEPTH = 8192;
	localparam int DEF_NUM_BANKS  = 3;

	// Host bus field widths
	localparam int CHIP_W    = 2;
	localparam int BUS_W     = 13;
	localparam int NARROW_AW = 11;
	localparam int WE_BIT    = 11;
	localparam int DATA_W    = 8;
	localparam int CNT_W     = 16;

	// Stream packing
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 24;

	typedef logic [DATA_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  count_t;

endpackage

[design/bsram_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bsram_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	// contents start at zero on power-up; reset leaves them alone
	logic [WIDTH-1:0] mem [DEPTH] = '{default: '0};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/banked_sram_emulator_with_access_counts.sv]
// Banked SRAM emulator with per-location access counters: top level.
// Depends on bsram_pkg and instantiates bsram_ram for the byte store and the counters.
//
// Stands in for NUM_BANKS byte-wide static RAM chips on a host bus. Each input
// transaction is one bus access; each produces exactly one output transaction
// carrying the read byte (zero on a write), the bus-drive flag and the access
// count of the location after increment (16 bits, wrapping). Throughput is one
// transaction per clock while the output is not stalled: the counter RAM is read in
// the accept cycle and written back when the access leaves stage 1, and a one-entry
// forwarding register covers a back-to-back access to the same location. The result
// reaches the output through the stage 1 register and the output register. After
// every reset the block sweeps all NUM_BANKS*BANK_DEPTH counter entries (24576 at
// the defaults) to zero, one entry per cycle; s_tready stays low during the sweep,
// while mode writes are taken as usual. The byte store is never cleared: it keeps
// its contents across reset, and a location never written since power-up reads as
// zero. Write the mode register only while the block is idle.
module banked_sram_emulator_with_access_counts #(
	parameter int BANK_DEPTH = bsram_pkg::DEF_BANK_DEPTH,
	parameter int NUM_BANKS  = bsram_pkg::DEF_NUM_BANKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// mode register: 1 = wide 13-bit addressing, 0 = narrow 11-bit addressing
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	// host access stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [12:0] address_bus, [20:13] bus_data_in, [23:21] zero
	input  logic [bsram_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] chip_select, [2] output_enable_line
	input  logic [bsram_pkg::S_TUSER_W-1:0] s_tuser,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] read_data, [23:8] access_count
	output logic [bsram_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] drive_bus
	output logic                            m_tuser
);

	localparam int STORE_DEPTH = NUM_BANKS * BANK_DEPTH;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int DEPTH_W     = $clog2(BANK_DEPTH + 1);
	localparam int CMP_W       = (bsram_pkg::BUS_W > DEPTH_W) ? bsram_pkg::BUS_W : DEPTH_W;
	// number of conditional subtractions that bring any bus address below the bank depth
	localparam int MOD_STEPS   = ((1 << bsram_pkg::BUS_W) - 1) / BANK_DEPTH;
	localparam int SEL_W       = 4;
	localparam int LAST_BANK   = NUM_BANKS - 1;

	// ---------------------------------------------------------------
	// Mode register
	// ---------------------------------------------------------------
	logic wide_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (cfg_we) begin
			wide_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// Counter clearing sweep after reset
	// ---------------------------------------------------------------
	logic             clear_q;
	logic [IDX_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= 1'b1;
			clr_q   <= '0;
		end else if (clear_q) begin
			clr_q <= clr_q + IDX_W'(1);
			if (clr_q == IDX_W'(STORE_DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 0: decode the bus access and issue RAM reads
	// ---------------------------------------------------------------
	logic [bsram_pkg::CHIP_W-1:0]  chip_in;
	logic [bsram_pkg::BUS_W-1:0]   bus_in;
	logic                          oe_in;
	bsram_pkg::byte_t              data_in;
	logic [SEL_W-1:0]              chip_cl;
	logic [bsram_pkg::BUS_W-1:0]   masked;
	logic [CMP_W-1:0]              addr_mod;
	logic                          rd_s0;
	logic [IDX_W-1:0]              idx_s0;
	logic                          s_accept;

	assign chip_in = s_tuser[bsram_pkg::CHIP_W-1:0];
	assign oe_in   = s_tuser[bsram_pkg::CHIP_W];
	assign bus_in  = s_tdata[bsram_pkg::BUS_W-1:0];
	assign data_in = s_tdata[bsram_pkg::BUS_W +: bsram_pkg::DATA_W];

	always_comb begin
		// clamp out-of-range chip selects onto the last bank
		chip_cl = SEL_W'(chip_in);
		if (chip_cl >= SEL_W'(NUM_BANKS)) begin
			chip_cl = SEL_W'(LAST_BANK);
		end

		// wide mode reads on output-enable low; narrow mode reads on write-enable high
		if (wide_q) begin
			masked = bus_in;
			rd_s0  = !oe_in;
		end else begin
			masked = {{(bsram_pkg::BUS_W - bsram_pkg::NARROW_AW){1'b0}},
				bus_in[bsram_pkg::NARROW_AW-1:0]};
			rd_s0  = bus_in[bsram_pkg::WE_BIT];
		end

		// wrap the address into the bank
		addr_mod = CMP_W'(masked);
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (addr_mod >= CMP_W'(BANK_DEPTH)) begin
				addr_mod = addr_mod - CMP_W'(BANK_DEPTH);
			end
		end

		idx_s0 = IDX_W'(IDX_W'(chip_cl) * IDX_W'(BANK_DEPTH) + IDX_W'(addr_mod));
	end

	// ---------------------------------------------------------------
	// Stage 1: read-modify-write of the counter, byte store access
	// ---------------------------------------------------------------
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              rd_s1;
	bsram_pkg::byte_t  data_s1;
	logic              s1_fire;

	logic              out_v_q;
	bsram_pkg::byte_t  rdata_q;
	logic              drive_q;
	bsram_pkg::count_t count_q;

	// take a new access only when stage 1 is empty or empties in the same cycle
	assign s1_fire  = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !clear_q && (!v_s1 || s1_fire);
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_accept) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			idx_s1  <= idx_s0;
			rd_s1   <= rd_s0;
			data_s1 <= data_in;
		end
	end

	// RAM read data of the item in stage 1
	bsram_pkg::byte_t  byte_rdata;
	bsram_pkg::count_t cnt_rdata;

	// last write-back, forwarded when the next access hits the same entry
	logic              lw_v_q;
	logic [IDX_W-1:0]  lw_idx_q;
	bsram_pkg::count_t lw_cnt_q;
	bsram_pkg::byte_t  lw_byte_q;
	logic              lw_wr_q;

	logic              lw_hit;
	bsram_pkg::count_t cnt_new;
	bsram_pkg::byte_t  byte_old;

	always_comb begin
		lw_hit   = lw_v_q && (lw_idx_q == idx_s1);
		cnt_new  = (lw_hit ? lw_cnt_q : cnt_rdata) + bsram_pkg::CNT_W'(1);
		byte_old = (lw_hit && lw_wr_q) ? lw_byte_q : byte_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_v_q <= 1'b0;
		end else if (s1_fire) begin
			lw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			lw_idx_q  <= idx_s1;
			lw_cnt_q  <= cnt_new;
			lw_byte_q <= data_s1;
			lw_wr_q   <= !rd_s1;
		end
	end

	// counter write port: clearing sweep or write-back
	logic              cnt_we;
	logic [IDX_W-1:0]  cnt_waddr;
	bsram_pkg::count_t cnt_wdata;

	assign cnt_we    = clear_q || s1_fire;
	assign cnt_waddr = clear_q ? clr_q : idx_s1;
	assign cnt_wdata = clear_q ? '0 : cnt_new;

	bsram_ram #(
		.WIDTH (bsram_pkg::CNT_W),
		.DEPTH (STORE_DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (s_accept),
		.raddr (idx_s0),
		.rdata (cnt_rdata)
	);

	bsram_ram #(
		.WIDTH (bsram_pkg::DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_byte_ram (
		.clk   (clk),
		.we    (s1_fire && !rd_s1),
		.waddr (idx_s1),
		.wdata (data_s1),
		.re    (s_accept),
		.raddr (idx_s0),
		.rdata (byte_rdata)
	);

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_fire) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rdata_q <= rd_s1 ? byte_old : '0;
			drive_q <= rd_s1;
			count_q <= cnt_new;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {count_q, rdata_q};
	assign m_tuser  = drive_q;

endmodule
